@@ src/imu_serial_frame_decoder_assert.svh @@
// Assertion macros for the IMU serial frame decoder.
// Included by modules that assert; depends on nothing else.
`ifndef IMU_SERIAL_FRAME_DECODER_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition pre holds at an edge, so post holds at that same edge.
`define ISFD_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");
// Condition pre holds at an edge, so post holds at the next edge.
`define ISFD_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ISFD_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define ISFD_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ src/isfd_pkg.sv @@
// Shared types, codes and scale constants of the IMU serial frame decoder.
// No dependencies.
package isfd_pkg;

    localparam int FRAME_LEN_DEF   = 11;
    localparam int QUEUE_DEPTH_DEF = 2;
    // Last frame byte that carries type or axis data
    localparam int BODY_LAST       = 7;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam int AXIS_W  = 28;
    localparam int RAW_W   = 16;
    localparam int SCALE_W = 14;
    localparam int PROD_W  = RAW_W + SCALE_W;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    // One decoded frame waiting for scaling
    typedef struct packed {
        t_kind                    kind;
        logic signed [RAW_W-1:0]  raw_x;
        logic signed [RAW_W-1:0]  raw_y;
        logic signed [RAW_W-1:0]  raw_z;
    } t_frame_item;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic push;
        logic at_start;
    } t_front_stat;

    // raw*scale/32768 with 16 fractional bits reduces to raw*k
    function automatic logic signed [SCALE_W-1:0] kind_scale(input t_kind kind);
        logic signed [SCALE_W-1:0] k;
        unique case (kind)
            KIND_ACCEL: k = SCALE_W'(32);
            KIND_GYRO:  k = SCALE_W'(4000);
            KIND_ANGLE: k = SCALE_W'(360);
            default:    k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ src/isfd_front.sv @@
// Front end: byte collection, header hunt and type classification.
// Depends on isfd_pkg.
module isfd_front #(
    parameter int FRAME_LEN = isfd_pkg::FRAME_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_rx_stall,
    input  isfd_pkg::t_q_stat    i_q_stat,
    output isfd_pkg::t_front_stat o_stat,
    output isfd_pkg::t_frame_item o_item
);
    import isfd_pkg::*;

    localparam int IW = $clog2(FRAME_LEN);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);

    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [7:0]    r_body [1:BODY_LAST];
    logic [7:0]    view   [1:BODY_LAST];
    logic          last;
    logic          acc;
    logic          known;
    t_kind         kind;

    assign last       = (r_idx == LAST_IDX);
    assign o_rx_stall = last && i_q_stat.full;
    assign acc        = i_rx_valid && !o_rx_stall;

    // Forward the incoming byte when it lands on a body slot this cycle
    always_comb begin
        for (int k = 1; k <= BODY_LAST; k++) begin
            view[k] = (r_idx == IW'(k)) ? i_rx_byte : r_body[k];
        end
    end

    always_comb begin
        unique case (view[1])
            TYPE_ACCEL: begin kind = KIND_ACCEL; known = 1'b1; end
            TYPE_GYRO:  begin kind = KIND_GYRO;  known = 1'b1; end
            TYPE_ANGLE: begin kind = KIND_ANGLE; known = 1'b1; end
            default:    begin kind = KIND_ACCEL; known = 1'b0; end
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (acc) begin
            if (r_idx == '0 && i_rx_byte != HEADER_BYTE) begin
                n_idx = '0;
            end else if (last) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= BODY_LAST; k++) begin
            if (acc && r_idx == IW'(k)) begin
                r_body[k] <= i_rx_byte;
            end
        end
    end

    assign o_stat.push     = acc && last && known;
    assign o_stat.at_start = (r_idx == '0);
    assign o_item.kind     = kind;
    assign o_item.raw_x    = {view[3], view[2]};
    assign o_item.raw_y    = {view[5], view[4]};
    assign o_item.raw_z    = {view[7], view[6]};
endmodule

@@ src/isfd_queue.sv @@
// Short FIFO of decoded frames between front and back end.
// Depends on isfd_pkg.
module isfd_queue #(
    parameter int DEPTH = isfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  isfd_pkg::t_frame_item i_item,
    input  logic                  i_pop,
    output isfd_pkg::t_q_stat     o_stat,
    output isfd_pkg::t_frame_item o_item
);
    import isfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_frame_item   r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule

@@ src/isfd_back.sv @@
// Back end: constant scaling of the three axes into the output register.
// Depends on isfd_pkg.
module isfd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  isfd_pkg::t_q_stat                    i_q_stat,
    input  isfd_pkg::t_frame_item                i_item,
    output logic                                 o_pop,
    output logic                                 o_res_valid,
    input  logic                                 i_res_stall,
    output logic [1:0]                           o_packet_kind,
    output logic signed [isfd_pkg::AXIS_W-1:0]   o_axis_x,
    output logic signed [isfd_pkg::AXIS_W-1:0]   o_axis_y,
    output logic signed [isfd_pkg::AXIS_W-1:0]   o_axis_z
);
    import isfd_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    t_kind                     r_kind;
    logic signed [AXIS_W-1:0]  r_x;
    logic signed [AXIS_W-1:0]  r_y;
    logic signed [AXIS_W-1:0]  r_z;
    logic signed [SCALE_W-1:0] scale;
    logic signed [PROD_W-1:0]  prod_x;
    logic signed [PROD_W-1:0]  prod_y;
    logic signed [PROD_W-1:0]  prod_z;

    assign o_pop  = i_q_stat.valid && (!r_valid || !i_res_stall);
    assign scale  = kind_scale(i_item.kind);
    assign prod_x = PROD_W'(i_item.raw_x) * PROD_W'(scale);
    assign prod_y = PROD_W'(i_item.raw_y) * PROD_W'(scale);
    assign prod_z = PROD_W'(i_item.raw_z) * PROD_W'(scale);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_res_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_item.kind;
            r_x    <= prod_x[AXIS_W-1:0];
            r_y    <= prod_y[AXIS_W-1:0];
            r_z    <= prod_z[AXIS_W-1:0];
        end
    end

    assign o_res_valid   = r_valid;
    assign o_packet_kind = r_kind;
    assign o_axis_x      = r_x;
    assign o_axis_y      = r_y;
    assign o_axis_z      = r_z;
endmodule

@@ src/imu_serial_frame_decoder.sv @@
// IMU 11-byte serial frame decoder, top level; uses isfd_pkg, isfd_front,
// isfd_queue, isfd_back and the assertion macro header.
// Throughput: one byte per cycle; the input stalls only on the closing byte
// of a frame while the frame queue is full.
// With queue and output register empty, the closing byte once accepted is written
// into the queue, then loaded into the output register, where the result is valid.
// Reset (synchronous, active low) clears the byte index, queue and output valid.
`include "imu_serial_frame_decoder_assert.svh"
module imu_serial_frame_decoder #(
    parameter int FRAME_LEN   = isfd_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = isfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Byte input transaction
    input  logic                               i_rx_valid,
    output logic                               o_rx_stall,
    input  logic [7:0]                         i_rx_byte,
    // Result transaction
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output logic [1:0]                         o_packet_kind,
    output logic signed [isfd_pkg::AXIS_W-1:0] o_axis_x,
    output logic signed [isfd_pkg::AXIS_W-1:0] o_axis_y,
    output logic signed [isfd_pkg::AXIS_W-1:0] o_axis_z
);
    import isfd_pkg::*;

    t_front_stat front_stat;
    t_frame_item front_item;
    t_q_stat     q_stat;
    t_frame_item q_item;
    logic        pop;
    logic        rx_acc;

    assign rx_acc = i_rx_valid && !o_rx_stall;

    // Front: hunt for the header, collect the frame, classify the type byte.
    // Frames with an unknown type are consumed here and never queued.
    isfd_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_stall (o_rx_stall),
        .i_q_stat   (q_stat),
        .o_stat     (front_stat),
        .o_item     (front_item)
    );

    // Queue: decouples frame collection from the output stall.
    isfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_stat.push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_item  (q_item)
    );

    // Back: multiply each raw axis by the kind's constant, hold in the
    // output register until the transaction completes.
    isfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_item        (q_item),
        .o_pop         (pop),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_packet_kind (o_packet_kind),
        .o_axis_x      (o_axis_x),
        .o_axis_y      (o_axis_y),
        .o_axis_z      (o_axis_z)
    );

    // A frame is never pushed into a full queue
    `ISFD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, q_stat.full, !front_stat.push)
    // A pushed frame leaves the queue non-empty
    `ISFD_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, front_stat.push, q_stat.valid)
    // A non-header byte while hunting keeps the front hunting
    `ISFD_ASSERT_NXT(a_drop_noise, i_clk, i_rst_n,
        rx_acc && front_stat.at_start && i_rx_byte != HEADER_BYTE, front_stat.at_start)
    // Results only carry one of the three defined kinds
    `ISFD_ASSERT_IMP(a_kind_legal, i_clk, i_rst_n, o_res_valid, o_packet_kind != 2'd3)
endmodule

@@ tb/sv/isfd_frame_check.sv @@
// Checker for the IMU serial frame decoder: watches both transaction channels,
// predicts decoded frames and compares results. Depends on isfd_pkg.
module isfd_frame_check
    import isfd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rx_valid,
    input  logic                      i_rx_stall,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic [1:0]                i_packet_kind,
    input  logic signed [AXIS_W-1:0]  i_axis_x,
    input  logic signed [AXIS_W-1:0]  i_axis_y,
    input  logic signed [AXIS_W-1:0]  i_axis_z,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN = FRAME_LEN_DEF;
    // raw * full_scale * 65536 / 32768
    localparam int ACCEL_GAIN = 32;
    localparam int GYRO_GAIN  = 4000;
    localparam int ANGLE_GAIN = 360;

    typedef struct packed {
        t_kind                    kind;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_decoded;

    t_decoded   frames_due[$];
    logic [3:0] byte_pos = '0;
    logic [7:0] frame_buf[FRAME_LEN];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic signed [AXIS_W-1:0] scale_axis(input logic [7:0] lo,
                                                            input logic [7:0] hi,
                                                            input int gain);
        int raw;
        raw = $signed({hi, lo});
        return AXIS_W'(raw * gain);
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        t_decoded d;
        int       gain;
        logic     known;
        if (byte_pos >= FRAME_LEN) byte_pos = '0;
        if (byte_pos == 0 && b != HEADER_BYTE) return;
        frame_buf[byte_pos] = b;
        if (byte_pos + 1 < FRAME_LEN) begin
            byte_pos = byte_pos + 1'b1;
            return;
        end
        byte_pos = '0;
        known = 1'b1;
        gain = 0;
        d = '0;
        case (frame_buf[1])
            TYPE_ACCEL: begin d.kind = KIND_ACCEL; gain = ACCEL_GAIN; end
            TYPE_GYRO:  begin d.kind = KIND_GYRO;  gain = GYRO_GAIN;  end
            TYPE_ANGLE: begin d.kind = KIND_ANGLE; gain = ANGLE_GAIN; end
            default:    known = 1'b0;
        endcase
        if (known) begin
            d.x = scale_axis(frame_buf[2], frame_buf[3], gain);
            d.y = scale_axis(frame_buf[4], frame_buf[5], gain);
            d.z = scale_axis(frame_buf[6], frame_buf[7], gain);
            frames_due.push_back(d);
        end
    endtask

    function automatic void check_field(input string field,
                                        input logic signed [AXIS_W-1:0] want,
                                        input logic signed [AXIS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            byte_pos = '0;
            frames_due.delete();
        end else begin
            // compare first so a frame closed at this edge cannot match a result
            if (i_res_valid && !i_res_stall) begin
                if (frames_due.size() == 0) begin
                    $error("result with no frame pending: packet_kind %0d", i_packet_kind);
                    o_fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("packet_kind", AXIS_W'(want.kind), AXIS_W'(i_packet_kind));
                    check_field("axis_x", want.x, i_axis_x);
                    check_field("axis_y", want.y, i_axis_y);
                    check_field("axis_z", want.z, i_axis_z);
                end
            end
            if (i_rx_valid && !i_rx_stall) absorb_byte(i_rx_byte);
        end
        o_pending <= frames_due.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the IMU serial frame decoder testbench: clock, reset, byte stimulus,
// result-side stalls and the verdict. Depends on isfd_pkg and isfd_frame_check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import isfd_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEF;
    localparam int ITEM_GOAL = 1200;
    localparam int MAX_GAP   = 18;
    localparam int TAIL_WAIT = 8;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     rx_valid = 1'b0;
    logic [7:0]               rx_byte = '0;
    logic                     res_stall = 1'b0;
    logic                     rx_stall;
    logic                     res_valid;
    logic [1:0]               packet_kind;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    int                       fail_count;
    int                       pending;

    // Set to run stretches with no idling on either side
    bit          steady = 1'b0;
    int unsigned res_hold = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    imu_serial_frame_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (rx_valid),
        .o_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .o_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .o_packet_kind (packet_kind),
        .o_axis_x      (axis_x),
        .o_axis_y      (axis_y),
        .o_axis_z      (axis_z)
    );

    isfd_frame_check u_frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (rx_valid),
        .i_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_packet_kind (packet_kind),
        .i_axis_x      (axis_x),
        .i_axis_y      (axis_y),
        .i_axis_z      (axis_z),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Draw an idle count; at least a quarter of draws are zero so back-to-back runs occur too
    function automatic int unsigned draw_gap();
        if (steady) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Favor the axis extremes so the largest products show up for every kind
    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1, 2: return TYPE_ACCEL;
            3, 4, 5: return TYPE_GYRO;
            6, 7, 8: return TYPE_ANGLE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Hold valid low for a random gap, then present the byte and hold it
    // until the transaction completes. Valid is only lowered when there is a gap,
    // so a back-to-back byte never sees two assignments in one step.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (rx_stall);
    endtask

    // Header, type, three little-endian axes, then random trailing bytes
    // (checksum included; the block does not check it)
    task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z);
        send_byte(HEADER_BYTE);
        send_byte(kind_byte);
        send_byte(x[7:0]);
        send_byte(x[15:8]);
        send_byte(y[7:0]);
        send_byte(y[15:8]);
        send_byte(z[7:0]);
        send_byte(z[15:8]);
        repeat (FRAME_LEN - 8) send_byte(8'($urandom));
    endtask

    // Drop valid and hold off until every predicted frame has come out
    task automatic wait_drain();
        rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: after each accepted result, stall for a freshly drawn count
    always @(posedge i_clk) begin
        if (res_valid && !res_stall)
            res_hold = draw_gap();
        else if (res_hold != 0)
            res_hold = res_hold - 1;
        res_stall <= (res_hold != 0);
    end

    initial begin
        int unsigned sent;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle bytes: both byte extremes and a bare type byte are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TYPE_ACCEL);
        // Axis extremes: most negative, most positive, minus one
        send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
        // Header bytes inside the frame are plain data, no resync
        send_frame(TYPE_ANGLE, 16'h5555, 16'h0055, 16'h5500);
        wait_drain();

        sent = 0;
        while (sent < ITEM_GOAL) begin
            steady = (sent >= 400 && sent < 550);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                // well-formed frame, random content
                send_frame(pick_type(), pick_axis(), pick_axis(), pick_axis());
                sent += FRAME_LEN;
            end else if (pick < 87) begin
                // line noise between frames
                repeat ($urandom_range(1, 4)) begin
                    do b = 8'($urandom); while (b == HEADER_BYTE);
                    send_byte(b);
                end
            end else if (pick < 97) begin
                // truncated frame: the next bytes complete it
                n = $urandom_range(1, FRAME_LEN - 2);
                send_byte(HEADER_BYTE);
                repeat (n) send_byte(8'($urandom));
                sent += n + 1;
            end else begin
                wait_drain();
            end
        end
        steady = 1'b0;

        wait_drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS imu_serial_frame_decoder");
        end else begin
            $display("FAIL imu_serial_frame_decoder");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAIL imu_serial_frame_decoder");
        $finish;
    end

endmodule

@@ imu_serial_frame_decoder.f @@
+incdir+src
src/isfd_pkg.sv
src/isfd_front.sv
src/isfd_queue.sv
src/isfd_back.sv
src/imu_serial_frame_decoder.sv
tb/sv/isfd_frame_check.sv
tb/sv/tb_top.sv
